>>> src/mmf_pkg.sv
package mmf_pkg;

  // Defaults for the top-level parameters
  localparam int MAX_DIM_DEF = 8;
  localparam int ELEM_W_DEF  = 16;

  // Fixed field widths
  localparam int OP_W    = 2;
  localparam int IDX_W   = 3;
  localparam int CFG_W   = 4;
  localparam int APB_W   = 32;
  localparam int PADDR_W = 4;
  localparam int REG_W   = 2;

  // Operation codes
  localparam logic [OP_W-1:0] OP_WR_A    = 2'd0;
  localparam logic [OP_W-1:0] OP_WR_B    = 2'd1;
  localparam logic [OP_W-1:0] OP_COMPUTE = 2'd2;

  // Register indexes (byte address = 4 * index)
  localparam logic [REG_W-1:0] REG_ROWS_M  = 2'd0;
  localparam logic [REG_W-1:0] REG_COLS_N  = 2'd1;
  localparam logic [REG_W-1:0] REG_INNER_K = 2'd2;

  localparam logic [CFG_W-1:0] DIM_RESET = 4'd8;

  // Tag that travels with each read pair through the multiply-accumulate pipe
  typedef struct packed {
    logic vld;
    logic first;
    logic last;
  } mmf_issue_t;

endpackage

>>> src/mmf_ram.sv
module mmf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> src/mmf_mac.sv
module mmf_mac #(
  parameter int MAX_DIM       = mmf_pkg::MAX_DIM_DEF,
  parameter int ELEMENT_WIDTH = mmf_pkg::ELEM_W_DEF
) (
  input  logic                                                  clk,
  input  logic                                                  rst_n,
  input  mmf_pkg::mmf_issue_t                                   issue,
  input  logic [ELEMENT_WIDTH-1:0]                              rdata_a,
  input  logic [ELEMENT_WIDTH-1:0]                              rdata_b,
  input  logic                                                  emit_ack,
  output logic signed [2*ELEMENT_WIDTH+$clog2(MAX_DIM)-1:0]     acc_sum,
  output logic                                                  acc_done
);

  import mmf_pkg::*;

  localparam int PROD_W = 2 * ELEMENT_WIDTH;
  localparam int RES_W  = PROD_W + $clog2(MAX_DIM);

  mmf_issue_t                s1_r, s2_r;
  logic signed [PROD_W-1:0]  prod_r, prod_nxt;
  logic signed [RES_W-1:0]   acc_r, acc_nxt, prod_ext;
  logic                      done_r, done_nxt;
  logic signed [ELEMENT_WIDTH-1:0] a_s, b_s;

  assign a_s      = rdata_a;
  assign b_s      = rdata_b;
  assign prod_nxt = a_s * b_s;
  assign prod_ext = RES_W'(prod_r);

  always_comb begin
    acc_nxt  = acc_r;
    done_nxt = done_r;
    if (s2_r.vld) begin
      acc_nxt = s2_r.first ? prod_ext : acc_r + prod_ext;
    end
    if (s2_r.vld && s2_r.last) begin
      done_nxt = 1'b1;
    end else if (emit_ack) begin
      done_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r   <= '0;
      s2_r   <= '0;
      done_r <= 1'b0;
    end else begin
      s1_r   <= issue;
      s2_r   <= s1_r;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    acc_r  <= acc_nxt;
  end

  assign acc_sum  = acc_r;
  assign acc_done = done_r;

  // A finished sum waits only with the pipe empty
  a_done_pipe_empty: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> (!s1_r.vld && !s2_r.vld))
    else $error("mmf_mac: products in flight while a sum waits");

  // The last product of an element always marks the sum done
  a_done_from_last: assert property (@(posedge clk) disable iff (!rst_n)
    (s2_r.vld && s2_r.last) |=> done_r)
    else $error("mmf_mac: last product did not mark the sum done");

endmodule

>>> src/mmf_seq.sv
module mmf_seq #(
  parameter int MAX_DIM       = mmf_pkg::MAX_DIM_DEF,
  parameter int ELEMENT_WIDTH = mmf_pkg::ELEM_W_DEF
) (
  input  logic                                              clk,
  input  logic                                              rst_n,
  input  logic                                              start,
  input  logic [$clog2(MAX_DIM+1)-1:0]                      m_dim,
  input  logic [$clog2(MAX_DIM+1)-1:0]                      n_dim,
  input  logic [$clog2(MAX_DIM+1)-1:0]                      k_dim,
  input  logic signed [2*ELEMENT_WIDTH+$clog2(MAX_DIM)-1:0] acc_sum,
  input  logic                                              acc_done,
  input  logic                                              out_stall,
  output logic                                              busy,
  output mmf_pkg::mmf_issue_t                               issue,
  output logic [$clog2(MAX_DIM*MAX_DIM)-1:0]                rd_addr_a,
  output logic [$clog2(MAX_DIM*MAX_DIM)-1:0]                rd_addr_b,
  output logic                                              emit_ack,
  output logic                                              out_valid,
  output logic [mmf_pkg::IDX_W-1:0]                         out_row,
  output logic [mmf_pkg::IDX_W-1:0]                         out_col,
  output logic signed [2*ELEMENT_WIDTH+$clog2(MAX_DIM)-1:0] out_value,
  output logic                                              out_last
);

  import mmf_pkg::*;

  localparam int IW    = $clog2(MAX_DIM);
  localparam int AW    = $clog2(MAX_DIM * MAX_DIM);
  localparam int DIM_W = $clog2(MAX_DIM + 1);
  localparam int RES_W = 2 * ELEMENT_WIDTH + IW;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_WAIT = 2'd2;

  logic [1:0]              state_r, state_nxt;
  logic [IW-1:0]           i_r, i_nxt, j_r, j_nxt, t_r, t_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic [IDX_W-1:0]        out_row_r, out_col_r;
  logic signed [RES_W-1:0] out_value_r;
  logic                    out_last_r;
  logic                    t_last, j_last, i_last, elem_last, slot_free, emit;

  assign t_last    = DIM_W'(t_r) == (k_dim - DIM_W'(1));
  assign j_last    = DIM_W'(j_r) == (n_dim - DIM_W'(1));
  assign i_last    = DIM_W'(i_r) == (m_dim - DIM_W'(1));
  assign elem_last = i_last && j_last;
  assign slot_free = !out_valid_r || !out_stall;
  assign emit      = (state_r == ST_WAIT) && acc_done && slot_free;

  assign issue.vld   = (state_r == ST_RUN);
  assign issue.first = (t_r == '0);
  assign issue.last  = t_last;
  assign rd_addr_a   = AW'(i_r) * AW'(MAX_DIM) + AW'(t_r);
  assign rd_addr_b   = AW'(t_r) * AW'(MAX_DIM) + AW'(j_r);

  always_comb begin
    state_nxt = state_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    t_nxt     = t_r;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt = ST_RUN;
          i_nxt     = '0;
          j_nxt     = '0;
          t_nxt     = '0;
        end
      end
      ST_RUN: begin
        if (t_last) begin
          t_nxt     = '0;
          state_nxt = ST_WAIT;
        end else begin
          t_nxt = t_r + IW'(1);
        end
      end
      ST_WAIT: begin
        if (emit) begin
          if (elem_last) begin
            state_nxt = ST_IDLE;
          end else begin
            state_nxt = ST_RUN;
            if (j_last) begin
              j_nxt = '0;
              i_nxt = i_r + IW'(1);
            end else begin
              j_nxt = j_r + IW'(1);
            end
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_valid_nxt = emit || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      i_r         <= '0;
      j_r         <= '0;
      t_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      i_r         <= i_nxt;
      j_r         <= j_nxt;
      t_r         <= t_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_row_r   <= IDX_W'(i_r);
      out_col_r   <= IDX_W'(j_r);
      out_value_r <= acc_sum;
      out_last_r  <= elem_last;
    end
  end

  assign busy      = (state_r != ST_IDLE);
  assign emit_ack  = emit;
  assign out_valid = out_valid_r;
  assign out_row   = out_row_r;
  assign out_col   = out_col_r;
  assign out_value = out_value_r;
  assign out_last  = out_last_r;

  // No stale sum may be pending while the next element is being read
  a_run_no_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RUN) |-> !acc_done)
    else $error("mmf_seq: sum pending while issuing reads");

  // The final element of a run returns the walker to idle
  a_last_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && elem_last) |=> (state_r == ST_IDLE && out_valid_r && out_last_r))
    else $error("mmf_seq: run did not end after its last element");

endmodule

>>> src/matrix_multiply_fixed.sv
// Channel   Direction  Handshake               Payload
// in_*      input      in_valid / in_stall     operation, row_index, col_index, element_value
// out_*     output     out_valid / out_stall   result_row, result_col, result_value, last
// APB       input      psel, penable, pwrite   paddr, pwdata -> rows_m, cols_n, inner_k
//
// An element write does not stall the input; a new transaction is taken in the next cycle.
// A compute transaction walks the m*n C elements in turn: one shared multiply-accumulate
// unit reads one A and one B entry per cycle (one read port per store), and each C
// element's sum then passes the read, multiply and add registers before it is emitted.
// in_stall is high while a compute walk runs; out_stall holds the output register
// and pauses the walk before the next element is loaded.
// rst_n is synchronous; the stores are not cleared and hold garbage until written.
module matrix_multiply_fixed #(
  parameter int MAX_DIM       = mmf_pkg::MAX_DIM_DEF,
  parameter int ELEMENT_WIDTH = mmf_pkg::ELEM_W_DEF
) (
  input  logic                                              clk,
  input  logic                                              rst_n,
  // input transactions
  input  logic                                              in_valid,
  output logic                                              in_stall,
  input  logic [mmf_pkg::OP_W-1:0]                          in_operation,
  input  logic [mmf_pkg::IDX_W-1:0]                         in_row_index,
  input  logic [mmf_pkg::IDX_W-1:0]                         in_col_index,
  input  logic signed [ELEMENT_WIDTH-1:0]                   in_element_value,
  // result transactions
  output logic                                              out_valid,
  input  logic                                              out_stall,
  output logic [mmf_pkg::IDX_W-1:0]                         out_result_row,
  output logic [mmf_pkg::IDX_W-1:0]                         out_result_col,
  output logic signed [2*ELEMENT_WIDTH+$clog2(MAX_DIM)-1:0] out_result_value,
  output logic                                              out_last,
  // configuration
  input  logic                                              psel,
  input  logic                                              penable,
  input  logic                                              pwrite,
  input  logic [mmf_pkg::PADDR_W-1:0]                       paddr,
  input  logic [mmf_pkg::APB_W-1:0]                         pwdata,
  output logic [mmf_pkg::APB_W-1:0]                         prdata,
  output logic                                              pready
);

  import mmf_pkg::*;

  localparam int DEPTH = MAX_DIM * MAX_DIM;
  localparam int AW    = $clog2(DEPTH);
  localparam int DIM_W = $clog2(MAX_DIM + 1);

  // Size registers as written; clamped below
  logic [CFG_W-1:0] rows_m_r, cols_n_r, inner_k_r;
  logic [CFG_W-1:0] m_full, n_full, k_full;
  logic [DIM_W-1:0] m_dim, n_dim, k_dim;
  logic [REG_W-1:0] reg_idx;
  logic             cfg_wr;

  logic             in_acc, wr_a, wr_b, start;
  logic [AW-1:0]    wr_addr, rd_addr_a, rd_addr_b;
  logic [ELEMENT_WIDTH-1:0] rdata_a, rdata_b;
  mmf_issue_t       issue;
  logic             busy, emit_ack, acc_done;
  logic signed [2*ELEMENT_WIDTH+$clog2(MAX_DIM)-1:0] acc_sum;

  // ---------------------------------------------------------------- config
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_idx = paddr[PADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_m_r  <= DIM_RESET;
      cols_n_r  <= DIM_RESET;
      inner_k_r <= DIM_RESET;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_ROWS_M:  rows_m_r  <= pwdata[CFG_W-1:0];
        REG_COLS_N:  cols_n_r  <= pwdata[CFG_W-1:0];
        REG_INNER_K: inner_k_r <= pwdata[CFG_W-1:0];
        default: begin
          // address past the register list: drop the write
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_ROWS_M:  prdata = APB_W'(rows_m_r);
      REG_COLS_N:  prdata = APB_W'(cols_n_r);
      REG_INNER_K: prdata = APB_W'(inner_k_r);
      default:     prdata = '0;
    endcase
  end

  // Zero acts as one, anything above MAX_DIM acts as MAX_DIM
  always_comb begin
    m_full = (rows_m_r == '0) ? CFG_W'(1) :
             (rows_m_r > CFG_W'(MAX_DIM)) ? CFG_W'(MAX_DIM) : rows_m_r;
    n_full = (cols_n_r == '0) ? CFG_W'(1) :
             (cols_n_r > CFG_W'(MAX_DIM)) ? CFG_W'(MAX_DIM) : cols_n_r;
    k_full = (inner_k_r == '0) ? CFG_W'(1) :
             (inner_k_r > CFG_W'(MAX_DIM)) ? CFG_W'(MAX_DIM) : inner_k_r;
  end

  assign m_dim = DIM_W'(m_full);
  assign n_dim = DIM_W'(n_full);
  assign k_dim = DIM_W'(k_full);

  // ---------------------------------------------------------- input decode
  // Take a transaction only while no compute walk is running
  assign in_stall = busy;
  assign in_acc   = in_valid && !in_stall;

  // Drop element writes that fall outside the sizes in force
  assign wr_a  = in_acc && (in_operation == OP_WR_A) &&
                 (CFG_W'(in_row_index) < m_full) && (CFG_W'(in_col_index) < k_full);
  assign wr_b  = in_acc && (in_operation == OP_WR_B) &&
                 (CFG_W'(in_row_index) < k_full) && (CFG_W'(in_col_index) < n_full);
  assign start = in_acc && (in_operation == OP_COMPUTE);

  // Row-major entry, MAX_DIM entries per row
  assign wr_addr = AW'(in_row_index) * AW'(MAX_DIM) + AW'(in_col_index);

  // ---------------------------------------------------------------- stores
  mmf_ram #(
    .WIDTH (ELEMENT_WIDTH),
    .DEPTH (DEPTH)
  ) u_a_store (
    .clk   (clk),
    .we    (wr_a),
    .waddr (wr_addr),
    .wdata (in_element_value),
    .re    (issue.vld),
    .raddr (rd_addr_a),
    .rdata (rdata_a)
  );

  mmf_ram #(
    .WIDTH (ELEMENT_WIDTH),
    .DEPTH (DEPTH)
  ) u_b_store (
    .clk   (clk),
    .we    (wr_b),
    .waddr (wr_addr),
    .wdata (in_element_value),
    .re    (issue.vld),
    .raddr (rd_addr_b),
    .rdata (rdata_b)
  );

  // ------------------------------------------------- walker and output reg
  mmf_seq #(
    .MAX_DIM       (MAX_DIM),
    .ELEMENT_WIDTH (ELEMENT_WIDTH)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .m_dim     (m_dim),
    .n_dim     (n_dim),
    .k_dim     (k_dim),
    .acc_sum   (acc_sum),
    .acc_done  (acc_done),
    .out_stall (out_stall),
    .busy      (busy),
    .issue     (issue),
    .rd_addr_a (rd_addr_a),
    .rd_addr_b (rd_addr_b),
    .emit_ack  (emit_ack),
    .out_valid (out_valid),
    .out_row   (out_result_row),
    .out_col   (out_result_col),
    .out_value (out_result_value),
    .out_last  (out_last)
  );

  // ------------------------------------------------ multiply-accumulate
  mmf_mac #(
    .MAX_DIM       (MAX_DIM),
    .ELEMENT_WIDTH (ELEMENT_WIDTH)
  ) u_mac (
    .clk      (clk),
    .rst_n    (rst_n),
    .issue    (issue),
    .rdata_a  (rdata_a),
    .rdata_b  (rdata_b),
    .emit_ack (emit_ack),
    .acc_sum  (acc_sum),
    .acc_done (acc_done)
  );

endmodule

>>> sim/tb.sv
`timescale 1ns / 100ps

module tb;
  import mmf_pkg::*;

  localparam int DIM      = MAX_DIM_DEF;
  localparam int EW       = ELEM_W_DEF;
  localparam int SUM_W    = 2 * EW + $clog2(DIM);
  // Operation code with no meaning to the block: it must be dropped silently
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  // One input transaction as the driver presents it
  typedef struct {
    logic [OP_W-1:0]        op;
    logic [IDX_W-1:0]       row;
    logic [IDX_W-1:0]       col;
    logic signed [EW-1:0]   val;
  } mm_req_t;

  // One element of the product matrix as it should leave the block
  typedef struct {
    logic [IDX_W-1:0]       row;
    logic [IDX_W-1:0]       col;
    logic signed [SUM_W-1:0] value;
    logic                   last;
  } c_elem_t;

  logic                     clk;
  logic                     rst_n;
  logic                     in_valid;
  logic                     in_stall;
  logic [OP_W-1:0]          in_operation;
  logic [IDX_W-1:0]         in_row_index;
  logic [IDX_W-1:0]         in_col_index;
  logic signed [EW-1:0]     in_element_value;
  logic                     out_valid;
  logic                     out_stall;
  logic [IDX_W-1:0]         out_result_row;
  logic [IDX_W-1:0]         out_result_col;
  logic signed [SUM_W-1:0]  out_result_value;
  logic                     out_last;
  logic                     psel;
  logic                     penable;
  logic                     pwrite;
  logic [PADDR_W-1:0]       paddr;
  logic [APB_W-1:0]         pwdata;
  logic [APB_W-1:0]         prdata;
  logic                     pready;

  matrix_multiply_fixed i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_operation     (in_operation),
    .in_row_index     (in_row_index),
    .in_col_index     (in_col_index),
    .in_element_value (in_element_value),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_result_row   (out_result_row),
    .out_result_col   (out_result_col),
    .out_result_value (out_result_value),
    .out_last         (out_last),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  // Transactions waiting for the driver, and product elements waiting for the monitor
  mm_req_t  req_q[$];
  c_elem_t  c_expect_q[$];

  // Shadow copy of the block: operand stores and raw size registers
  logic signed [EW-1:0] a_mem [DIM*DIM];
  logic signed [EW-1:0] b_mem [DIM*DIM];
  logic [CFG_W-1:0]     cfg_m_q = DIM_RESET;
  logic [CFG_W-1:0]     cfg_n_q = DIM_RESET;
  logic [CFG_W-1:0]     cfg_k_q = DIM_RESET;

  // Stimulus side view: sizes of the current phase and which entries hold data,
  // so that a compute never reads an entry that was never written
  int  pm = DIM;
  int  pn = DIM;
  int  pk = DIM;
  bit  a_loaded [DIM*DIM];
  bit  b_loaded [DIM*DIM];

  int  err_cnt   = 0;
  int  sent_cnt  = 0;
  bit  idle_on   = 1'b0;
  bit  in_taken  = 1'b0;
  int  in_gap    = 0;
  int  out_hold  = 0;
  mm_req_t  nxt;
  c_elem_t  got;
  c_elem_t  want;

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // A size register of zero acts as one, anything above the array size as the array size
  function automatic int eff_dim(logic [CFG_W-1:0] v);
    if (v == 0) return 1;
    if (v > DIM) return DIM;
    return int'(v);
  endfunction

  // Apply one accepted transaction to the shadow state; queue the product on a compute
  function automatic void matmul_apply(mm_req_t t);
    int      m;
    int      n;
    int      k;
    longint  acc;
    c_elem_t e;
    m = eff_dim(cfg_m_q);
    n = eff_dim(cfg_n_q);
    k = eff_dim(cfg_k_q);
    case (t.op)
      OP_WR_A: begin
        if (t.row < m && t.col < k) a_mem[t.row * DIM + t.col] = t.val;
      end
      OP_WR_B: begin
        if (t.row < k && t.col < n) b_mem[t.row * DIM + t.col] = t.val;
      end
      OP_COMPUTE: begin
        for (int i = 0; i < m; i++) begin
          for (int j = 0; j < n; j++) begin
            acc = 0;
            for (int p = 0; p < k; p++) begin
              acc += longint'(a_mem[i * DIM + p]) * longint'(b_mem[p * DIM + j]);
            end
            e.row   = IDX_W'(i);
            e.col   = IDX_W'(j);
            e.value = acc[SUM_W-1:0];
            e.last  = (i == m - 1) && (j == n - 1);
            c_expect_q.push_back(e);
          end
        end
      end
      default: ;
    endcase
  endfunction

  // Mostly random values, with a bias toward the full-scale corners and zero
  function automatic logic signed [EW-1:0] rand_elem();
    case ($urandom_range(0, 7))
      0:       return -16'sd32768;
      1:       return 16'sd32767;
      2:       return '0;
      default: return EW'($urandom);
    endcase
  endfunction

  // Queue a transaction; return 1 when it will change state or produce output
  function automatic bit push_req(logic [OP_W-1:0] op, logic [IDX_W-1:0] r,
                                  logic [IDX_W-1:0] c, logic signed [EW-1:0] v);
    bit hit;
    hit = 1'b0;
    req_q.push_back('{op, r, c, v});
    sent_cnt++;
    case (op)
      OP_WR_A: begin
        hit = (r < pm) && (c < pk);
        if (hit) a_loaded[r * DIM + c] = 1'b1;
      end
      OP_WR_B: begin
        hit = (r < pk) && (c < pn);
        if (hit) b_loaded[r * DIM + c] = 1'b1;
      end
      OP_COMPUTE: hit = 1'b1;
      default: ;
    endcase
    return hit;
  endfunction

  // Write every operand entry the current sizes reach: all of them when forced,
  // else only the holes, with one constant or with random values
  task automatic load_operands(bit force_all, bit use_const, logic signed [EW-1:0] cval);
    for (int i = 0; i < pm; i++) begin
      for (int p = 0; p < pk; p++) begin
        if (force_all || !a_loaded[i * DIM + p]) begin
          void'(push_req(OP_WR_A, IDX_W'(i), IDX_W'(p), use_const ? cval : rand_elem()));
        end
      end
    end
    for (int p = 0; p < pk; p++) begin
      for (int j = 0; j < pn; j++) begin
        if (force_all || !b_loaded[p * DIM + j]) begin
          void'(push_req(OP_WR_B, IDX_W'(p), IDX_W'(j), use_const ? cval : rand_elem()));
        end
      end
    end
  endtask

  // Fill any holes, then ask for the product
  task automatic issue_compute();
    load_operands(1'b0, 1'b0, '0);
    void'(push_req(OP_COMPUTE, IDX_W'($urandom), IDX_W'($urandom), EW'($urandom)));
  endtask

  // Hold until every queued transaction is taken and every product element has left,
  // then let the pipe drain
  task automatic wait_idle();
    while (req_q.size() != 0 || in_valid || c_expect_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // Register write: setup, then access until pready
  task automatic apb_write(logic [REG_W-1:0] idx, logic [CFG_W-1:0] val);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= APB_W'(val);
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_ROWS_M:  cfg_m_q = val;
      REG_COLS_N:  cfg_n_q = val;
      REG_INNER_K: cfg_k_q = val;
      default: ;
    endcase
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Reprogram all three sizes once the block has gone quiet
  task automatic set_dims(logic [CFG_W-1:0] m, logic [CFG_W-1:0] n, logic [CFG_W-1:0] k);
    wait_idle();
    apb_write(REG_ROWS_M, m);
    apb_write(REG_COLS_N, n);
    apb_write(REG_INNER_K, k);
    pm = eff_dim(m);
    pn = eff_dim(n);
    pk = eff_dim(k);
  endtask

  // Size register value for a random phase: mostly small, sometimes an extreme
  function automatic logic [CFG_W-1:0] rand_dim();
    case ($urandom_range(0, 19))
      0:       return '0;
      1:       return '1;
      2:       return CFG_W'(DIM);
      default: return CFG_W'($urandom_range(1, 4));
    endcase
  endfunction

  // Input side: record every transaction taken at the rising edge
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) begin
      matmul_apply('{in_operation, in_row_index, in_col_index, in_element_value});
      in_taken = 1'b1;
    end
  end

  // Input driver: advance at the falling edge only when the slot is free or was taken;
  // a stalled transaction stays on the pins untouched
  always @(negedge clk) begin
    if (rst_n && (!in_valid || in_taken)) begin
      in_taken = 1'b0;
      if (in_gap > 0) begin
        in_gap--;
        in_valid <= 1'b0;
      end else if (req_q.size() != 0) begin
        nxt = req_q.pop_front();
        in_valid         <= 1'b1;
        in_operation     <= nxt.op;
        in_row_index     <= nxt.row;
        in_col_index     <= nxt.col;
        in_element_value <= nxt.val;
        // Open an idle burst after this transaction now and then
        if (idle_on && $urandom_range(0, 3) == 0) in_gap = $urandom_range(1, 13);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Output monitor: match each element taken against the oldest one predicted
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      got = '{out_result_row, out_result_col, out_result_value, out_last};
      if (c_expect_q.size() == 0) begin
        err_cnt++;
        $display("%0t: unexpected element row %0d col %0d value %0d last %0b",
                 $time, got.row, got.col, got.value, got.last);
      end else begin
        want = c_expect_q.pop_front();
        if (got.row !== want.row || got.col !== want.col ||
            got.value !== want.value || got.last !== want.last) begin
          err_cnt++;
          $display("%0t: mismatch, expected row %0d col %0d value %0d last %0b",
                   $time, want.row, want.col, want.value, want.last);
          $display("%0t:           actual   row %0d col %0d value %0d last %0b",
                   $time, got.row, got.col, got.value, got.last);
        end
      end
    end
  end

  // Output back-pressure: stall in random bursts, none once idling is switched off
  always @(negedge clk) begin
    if (out_hold > 0) begin
      out_hold--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
      if (idle_on && $urandom_range(0, 5) == 0) out_hold = $urandom_range(1, 13);
    end
  end

  // Hard limit on the run
  initial begin
    #1000000;
    $display("Some tests failed");
    $finish;
  end

  initial begin
    int n_ops;
    logic [OP_W-1:0] noise_op;
    rst_n            = 1'b0;
    in_valid         = 1'b0;
    in_operation     = OP_WR_A;
    in_row_index     = '0;
    in_col_index     = '0;
    in_element_value = '0;
    out_stall        = 1'b0;
    psel             = 1'b0;
    penable          = 1'b0;
    pwrite           = 1'b0;
    paddr            = '0;
    pwdata           = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    idle_on = 1'b1;

    // Single-element product: most negative squared, then writes outside the
    // sizes and an unused operation code, none of which may disturb the result
    set_dims(4'd1, 4'd1, 4'd1);
    void'(push_req(OP_WR_A, 3'd0, 3'd0, -16'sd32768));
    void'(push_req(OP_WR_B, 3'd0, 3'd0, -16'sd32768));
    void'(push_req(OP_COMPUTE, 3'd0, 3'd0, '0));
    void'(push_req(OP_WR_A, 3'd1, 3'd0, 16'sd5));
    void'(push_req(OP_WR_A, 3'd0, 3'd1, 16'sd6));
    void'(push_req(OP_WR_B, 3'd1, 3'd0, 16'sd7));
    void'(push_req(OP_WR_B, 3'd0, 3'd7, 16'sd8));
    void'(push_req(OP_UNUSED, 3'd7, 3'd7, 16'sd32767));
    void'(push_req(OP_COMPUTE, 3'd7, 3'd7, -16'sd1));

    // Size registers of zero act as one
    set_dims(4'd0, 4'd0, 4'd0);
    void'(push_req(OP_WR_A, 3'd0, 3'd0, 16'sd32767));
    void'(push_req(OP_WR_B, 3'd0, 3'd0, 16'sd32767));
    void'(push_req(OP_WR_A, 3'd7, 3'd7, -16'sd1));
    void'(push_req(OP_COMPUTE, 3'd0, 3'd0, '0));

    // Longest inner sum with every product at full scale: the positive extreme
    set_dims(4'd1, 4'd1, 4'd8);
    load_operands(1'b1, 1'b1, -16'sd32768);
    void'(push_req(OP_COMPUTE, 3'd0, 3'd0, '0));

    // Every one of the 64 product elements through oversized row and column registers;
    // stores are kept across size changes
    set_dims(4'd15, 4'd15, 4'd1);
    issue_compute();

    // Random phases: new sizes each time, writes with random content, some noise,
    // computes that always find their operands written
    while (sent_cnt < 120) begin
      if (sent_cnt > 95) idle_on = 1'b0;
      set_dims(rand_dim(), rand_dim(), rand_dim());
      n_ops = $urandom_range(4, 16);
      repeat (n_ops) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4, 5: begin
            if ($urandom_range(0, 1) == 0) begin
              void'(push_req(OP_WR_A, IDX_W'($urandom_range(0, pm - 1)),
                             IDX_W'($urandom_range(0, pk - 1)), rand_elem()));
            end else begin
              void'(push_req(OP_WR_B, IDX_W'($urandom_range(0, pk - 1)),
                             IDX_W'($urandom_range(0, pn - 1)), rand_elem()));
            end
          end
          6: begin
            // Noise: any operation on any indices, mostly dropped by the block
            noise_op = OP_W'($urandom_range(0, 3));
            if (noise_op == OP_COMPUTE) begin
              issue_compute();
            end else begin
              void'(push_req(noise_op, IDX_W'($urandom), IDX_W'($urandom),
                             EW'($urandom)));
            end
          end
          default: issue_compute();
        endcase
      end
      issue_compute();
    end

    wait_idle();
    repeat (50) @(posedge clk);
    if (err_cnt == 0 && c_expect_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

>>> files.f
src/mmf_pkg.sv
src/mmf_ram.sv
src/mmf_mac.sv
src/mmf_seq.sv
src/matrix_multiply_fixed.sv
sim/tb.sv
